[hdl/sacl_pkg.sv]
// shared types and constants for the set-associative tag store
`default_nettype none
package sacl_pkg;

  localparam int SET_BITS   = 6;
  localparam int WAY_COUNT  = 16;
  localparam int ADDR_BITS  = 32;
  localparam int TAG_W      = ADDR_BITS - SET_BITS;
  localparam int SET_COUNT  = 1 << SET_BITS;
  localparam int WAY_BITS   = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int WAY_CNT_W  = $clog2(WAY_COUNT + 1);
  localparam int CNT_W      = 32;
  localparam int TS_W       = 32;
  localparam int CFG_W      = 5;
  localparam int PADDR_W    = 3;

  localparam logic [PADDR_W-1:0] REG_WAYS_ADDR = '0;
  localparam logic [CFG_W-1:0]   WAYS_RESET    = CFG_W'(WAY_COUNT);

  localparam logic OP_LOOKUP  = 1'b0;
  localparam logic OP_INSTALL = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [ADDR_BITS-1:0] line_addr;
    logic                 is_write;
    logic [TS_W-1:0]      timestamp;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic             evicted_dirty;
    logic [TAG_W-1:0] evicted_tag;
    logic [CNT_W-1:0] read_accesses;
    logic [CNT_W-1:0] write_accesses;
    logic [CNT_W-1:0] read_misses;
    logic [CNT_W-1:0] write_misses;
    logic [CNT_W-1:0] dirty_evictions;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
    logic [TS_W-1:0]  age;
  } way_t;

  typedef way_t [WAY_COUNT-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

endpackage
`default_nettype wire

[hdl/sacl_req_if.sv]
// request channel: valid, ready and one access beat
`default_nettype none
interface sacl_req_if;
  logic             valid;
  logic             ready;
  sacl_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hdl/sacl_rsp_if.sv]
// response channel: valid, ready and one result beat
`default_nettype none
interface sacl_rsp_if;
  logic             valid;
  logic             ready;
  sacl_pkg::rsp_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hdl/sacl_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/set_assoc_cache_tags_lru.sv]
// top level: set-associative tag store with lru replacement
// One access at a time. A lookup, or an install that finds a free way, goes through
// accept with set read, row capture, and compare and write back; the result is
// registered at the end of the compare step. An install into a full set then scans
// the age stamps of the ways in use one way per cycle. The whole set lives in one
// memory row, read once and written back at most once (not on a lookup miss); a
// flip-flop per set marks rows never written, which read as empty, so the store is
// clear right after reset with no sweep. A result waits in an output register while
// the next access is accepted; that access then holds in its compare step, or at the
// last way of its scan, until the result beat is taken.
`default_nettype none
module set_assoc_cache_tags_lru (
  input  wire logic       clk,
  input  wire logic       rst,
  sacl_req_if.sink        req,
  sacl_rsp_if.source      rsp,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [sacl_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0] state;
  logic [sacl_pkg::CFG_W-1:0] ways_cfg;
  logic [sacl_pkg::SET_COUNT-1:0] row_vld;
  sacl_pkg::req_t req_q;
  sacl_pkg::row_t row_q;
  sacl_pkg::row_t row_rd;
  sacl_pkg::row_t row_wr;
  logic [sacl_pkg::WAY_BITS-1:0] idx;
  logic [sacl_pkg::WAY_BITS-1:0] victim;
  logic [sacl_pkg::TS_W-1:0] best;
  logic [sacl_pkg::CNT_W-1:0] rd_acc, wr_acc, rd_miss, wr_miss, dirty_ev;
  logic res_hit, res_ev, res_evd;
  logic [sacl_pkg::TAG_W-1:0] res_tag;

  logic [sacl_pkg::WAY_CNT_W-1:0] n;
  logic [sacl_pkg::SET_BITS-1:0] set_q;
  logic [sacl_pkg::TAG_W-1:0] tag_q;
  logic hit_any, free_any, last, fin, do_fin, out_free, ram_we;
  logic [sacl_pkg::WAY_BITS-1:0] hit_way, free_way, victim_fin, sel_way;
  sacl_pkg::way_t cand;

  assign pready = 1'b1;
  assign prdata = (paddr == sacl_pkg::REG_WAYS_ADDR) ? 32'(ways_cfg) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_cfg <= sacl_pkg::WAYS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == sacl_pkg::REG_WAYS_ADDR) begin
      ways_cfg <= pwdata[sacl_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    if (ways_cfg == '0) begin
      n = sacl_pkg::WAY_CNT_W'(1);
    end else if (ways_cfg > sacl_pkg::CFG_W'(sacl_pkg::WAY_COUNT)) begin
      n = sacl_pkg::WAY_CNT_W'(sacl_pkg::WAY_COUNT);
    end else begin
      n = sacl_pkg::WAY_CNT_W'(ways_cfg);
    end
  end

  assign set_q = req_q.line_addr[sacl_pkg::SET_BITS-1:0];
  assign tag_q = req_q.line_addr[sacl_pkg::ADDR_BITS-1:sacl_pkg::SET_BITS];

  sacl_ram #(.WIDTH(sacl_pkg::ROW_W), .DEPTH(sacl_pkg::SET_COUNT)) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (set_q),
    .wdata (row_wr),
    .raddr (req.payload.line_addr[sacl_pkg::SET_BITS-1:0]),
    .rdata (row_rd)
  );

  // parallel compare, lowest matching / free way wins
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = sacl_pkg::WAY_COUNT - 1; w >= 0; w--) begin
      if (sacl_pkg::WAY_CNT_W'(w) < n) begin
        if (row_q[w].valid && row_q[w].tag == tag_q) begin
          hit_any = 1'b1;
          hit_way = sacl_pkg::WAY_BITS'(w);
        end
        if (!row_q[w].valid) begin
          free_any = 1'b1;
          free_way = sacl_pkg::WAY_BITS'(w);
        end
      end
    end
  end

  assign cand       = row_q[idx];
  assign victim_fin = (cand.age < best) ? idx : victim;
  assign last       = sacl_pkg::WAY_CNT_W'(idx) == n - sacl_pkg::WAY_CNT_W'(1);
  assign fin        = (state == S_EVAL && (req_q.op == sacl_pkg::OP_LOOKUP || free_any)) ||
                      (state == S_SCAN && last);
  assign out_free   = !rsp.valid || rsp.ready;
  assign do_fin     = fin && out_free;
  assign ram_we     = do_fin && (req_q.op == sacl_pkg::OP_INSTALL || hit_any);
  assign req.ready  = state == S_IDLE;

  always_comb begin
    if (state == S_SCAN) begin
      sel_way = victim_fin;
    end else if (req_q.op == sacl_pkg::OP_LOOKUP) begin
      sel_way = hit_way;
    end else begin
      sel_way = free_way;
    end
    row_wr = row_q;
    row_wr[sel_way].age = req_q.timestamp;
    if (req_q.op == sacl_pkg::OP_LOOKUP) begin
      row_wr[sel_way].dirty = row_q[sel_way].dirty | req_q.is_write;
    end else begin
      row_wr[sel_way].valid = 1'b1;
      row_wr[sel_way].dirty = req_q.is_write;
      row_wr[sel_way].tag   = tag_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      row_vld <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (do_fin) begin
            state <= S_IDLE;
          end else if (!fin) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (do_fin) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (ram_we) begin
        row_vld[set_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      req_q <= req.payload;
    end
    if (state == S_LOOK) begin
      row_q <= row_vld[set_q] ? row_rd : '0;
    end
    if (state == S_EVAL) begin
      idx    <= '0;
      victim <= '0;
      best   <= '1;
    end else if (state == S_SCAN && !last) begin
      idx    <= idx + sacl_pkg::WAY_BITS'(1);
      victim <= victim_fin;
      best   <= (cand.age < best) ? cand.age : best;
    end
  end

  // result register and saturating counters
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
      rd_acc    <= '0;
      wr_acc    <= '0;
      rd_miss   <= '0;
      wr_miss   <= '0;
      dirty_ev  <= '0;
    end else begin
      if (do_fin) begin
        rsp.valid <= 1'b1;
        if (req_q.op == sacl_pkg::OP_LOOKUP) begin
          if (req_q.is_write) begin
            wr_acc <= wr_acc + sacl_pkg::CNT_W'(wr_acc != '1);
            if (!hit_any) begin
              wr_miss <= wr_miss + sacl_pkg::CNT_W'(wr_miss != '1);
            end
          end else begin
            rd_acc <= rd_acc + sacl_pkg::CNT_W'(rd_acc != '1);
            if (!hit_any) begin
              rd_miss <= rd_miss + sacl_pkg::CNT_W'(rd_miss != '1);
            end
          end
        end else if (state == S_SCAN && row_q[victim_fin].dirty) begin
          dirty_ev <= dirty_ev + sacl_pkg::CNT_W'(dirty_ev != '1);
        end
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_fin) begin
      res_hit <= req_q.op == sacl_pkg::OP_LOOKUP && hit_any;
      res_ev  <= state == S_SCAN;
      res_evd <= state == S_SCAN && row_q[victim_fin].dirty;
      res_tag <= (state == S_SCAN) ? row_q[victim_fin].tag : '0;
    end
  end

  assign rsp.payload.hit             = res_hit;
  assign rsp.payload.evicted         = res_ev;
  assign rsp.payload.evicted_dirty   = res_evd;
  assign rsp.payload.evicted_tag     = res_tag;
  assign rsp.payload.read_accesses   = rd_acc;
  assign rsp.payload.write_accesses  = wr_acc;
  assign rsp.payload.read_misses     = rd_miss;
  assign rsp.payload.write_misses    = wr_miss;
  assign rsp.payload.dirty_evictions = dirty_ev;

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !ram_we) else $error("row write while idle");

  a_write_ends: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> state == S_IDLE) else $error("row write did not end the access");

  a_hit_xor_evict: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.payload.hit && rsp.payload.evicted))
    else $error("result shows both hit and eviction");

  a_fin_frees: assert property (@(posedge clk) disable iff (rst)
    do_fin |=> rsp.valid) else $error("finished access gave no result");

endmodule
`default_nettype wire

[bench/testbench.sv]
// testbench for the set-associative tag store: scoreboard prediction of lru results
`default_nettype none
module testbench;

  class cache_scoreboard;
    logic [sacl_pkg::TAG_W-1:0] tags [sacl_pkg::SET_COUNT*sacl_pkg::WAY_COUNT];
    bit                         vld  [sacl_pkg::SET_COUNT*sacl_pkg::WAY_COUNT];
    bit                         drt  [sacl_pkg::SET_COUNT*sacl_pkg::WAY_COUNT];
    logic [sacl_pkg::TS_W-1:0]  ages [sacl_pkg::SET_COUNT*sacl_pkg::WAY_COUNT];
    logic [sacl_pkg::CNT_W-1:0] rd_acc, wr_acc, rd_miss, wr_miss, dirty_ev;
    logic [sacl_pkg::CFG_W-1:0] ways;
    sacl_pkg::rsp_t             pending [$];
    int                         errors;

    function new();
      for (int i = 0; i < sacl_pkg::SET_COUNT*sacl_pkg::WAY_COUNT; i++) begin
        tags[i] = '0; vld[i] = 0; drt[i] = 0; ages[i] = '0;
      end
      rd_acc = '0; wr_acc = '0; rd_miss = '0; wr_miss = '0; dirty_ev = '0;
      ways = sacl_pkg::WAYS_RESET;
      errors = 0;
    endfunction

    function void bump(ref logic [sacl_pkg::CNT_W-1:0] c);
      if (c != '1) c = c + 1;
    endfunction

    function void note_access(sacl_pkg::req_t r);
      sacl_pkg::rsp_t o;
      int n, base, victim;
      logic [sacl_pkg::SET_BITS-1:0] set;
      logic [sacl_pkg::TAG_W-1:0] tg;
      logic [sacl_pkg::TS_W-1:0] best;
      n = (ways == 0) ? 1 : (ways > sacl_pkg::WAY_COUNT) ? sacl_pkg::WAY_COUNT : ways;
      set = r.line_addr[sacl_pkg::SET_BITS-1:0];
      tg = r.line_addr[sacl_pkg::ADDR_BITS-1:sacl_pkg::SET_BITS];
      base = set * sacl_pkg::WAY_COUNT;
      o = '0;
      if (r.op == sacl_pkg::OP_LOOKUP) begin
        if (r.is_write) bump(wr_acc); else bump(rd_acc);
        for (int w = 0; w < n; w++) begin
          if (vld[base+w] && tags[base+w] == tg) begin
            o.hit = 1; ages[base+w] = r.timestamp;
            if (r.is_write) drt[base+w] = 1;
            break;
          end
        end
        if (!o.hit) begin
          if (r.is_write) bump(wr_miss); else bump(rd_miss);
        end
      end else begin
        victim = n;
        for (int w = 0; w < n; w++)
          if (!vld[base+w]) begin victim = w; break; end
        if (victim == n) begin
          victim = 0; best = ages[base];
          for (int w = 1; w < n; w++)
            if (ages[base+w] < best) begin best = ages[base+w]; victim = w; end
          o.evicted = 1;
          o.evicted_dirty = drt[base+victim];
          o.evicted_tag = tags[base+victim];
          if (o.evicted_dirty) bump(dirty_ev);
        end
        tags[base+victim] = tg; vld[base+victim] = 1;
        drt[base+victim] = r.is_write; ages[base+victim] = r.timestamp;
      end
      o.read_accesses = rd_acc; o.write_accesses = wr_acc;
      o.read_misses = rd_miss; o.write_misses = wr_miss; o.dirty_evictions = dirty_ev;
      pending.push_back(o);
    endfunction

    function void check_result(sacl_pkg::rsp_t a);
      sacl_pkg::rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat"); errors++; return;
      end
      e = pending.pop_front();
      if (a.hit !== e.hit) begin
        $error("hit exp %0d got %0d", e.hit, a.hit); errors++;
      end
      if (a.evicted !== e.evicted) begin
        $error("evicted exp %0d got %0d", e.evicted, a.evicted); errors++;
      end
      if (a.evicted_dirty !== e.evicted_dirty) begin
        $error("evicted_dirty exp %0d got %0d", e.evicted_dirty, a.evicted_dirty); errors++;
      end
      if (a.evicted_tag !== e.evicted_tag) begin
        $error("evicted_tag exp %h got %h", e.evicted_tag, a.evicted_tag); errors++;
      end
      if (a.read_accesses !== e.read_accesses) begin
        $error("read_accesses exp %0d got %0d", e.read_accesses, a.read_accesses); errors++;
      end
      if (a.write_accesses !== e.write_accesses) begin
        $error("write_accesses exp %0d got %0d", e.write_accesses, a.write_accesses); errors++;
      end
      if (a.read_misses !== e.read_misses) begin
        $error("read_misses exp %0d got %0d", e.read_misses, a.read_misses); errors++;
      end
      if (a.write_misses !== e.write_misses) begin
        $error("write_misses exp %0d got %0d", e.write_misses, a.write_misses); errors++;
      end
      if (a.dirty_evictions !== e.dirty_evictions) begin
        $error("dirty_evictions exp %0d got %0d", e.dirty_evictions, a.dirty_evictions);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [sacl_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sacl_req_if req ();
  sacl_rsp_if rsp ();

  set_assoc_cache_tags_lru u_top (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  cache_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  hold_off = 0;
  bit  timed_out = 0;
  localparam int WATCHDOG = 20000;

  initial begin
    req.valid = 0;
    req.payload = '0;
    rsp.ready = 0;
  end

  // accept and result monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) sb.note_access(req.payload);
      if (rsp.valid && rsp.ready) sb.check_result(rsp.payload);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG && !timed_out) begin
        timed_out = 1;
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // receiver with random stalls and a long hold-off when asked
  initial begin
    int g;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        rsp.ready <= 0;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      g = gap_len();
      if (g == 0) begin
        rsp.ready <= 1;
        @(posedge clk);
      end else begin
        rsp.ready <= 0;
        repeat (g) @(posedge clk);
      end
    end
  end

  task automatic write_ways(input logic [sacl_pkg::CFG_W-1:0] v);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= sacl_pkg::REG_WAYS_ADDR;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.ways = v;
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // valid stays up after an accepted beat so the next one can follow with no gap
  task automatic send_access(input logic op, input logic [31:0] addr,
                             input logic wr, input logic [31:0] ts);
    sacl_pkg::req_t r;
    int g;
    g = (hold_off) ? 0 : gap_len();
    if (g > 0) begin
      req.valid <= 0;
      repeat (g) @(posedge clk);
    end
    r.op = op; r.line_addr = addr; r.is_write = wr; r.timestamp = ts;
    req.valid <= 1;
    req.payload <= r;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic drain();
    req.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // addresses from a small pool so sets fill and hit
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    if ($urandom_range(0, 9) == 0) return $urandom();
    a[5:0] = 6'($urandom_range(0, 3));
    a[31:6] = 26'($urandom_range(0, 23));
    if ($urandom_range(0, 7) == 0) a[31:6] = ~a[31:6];
    return a;
  endfunction

  initial begin
    logic [31:0] ts;
    logic [4:0] ways_list [6];
    ways_list = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd9};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    ts = 0;
    // directed: extremes, installs into full set, ties, dirty eviction, double install
    send_access(sacl_pkg::OP_LOOKUP, 32'h0, 0, 32'h0);
    send_access(sacl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
    send_access(sacl_pkg::OP_INSTALL, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
    send_access(sacl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 0, 32'h5);
    send_access(sacl_pkg::OP_INSTALL, 32'hFFFF_FFFF, 0, 32'h0);
    for (int i = 0; i < 16; i++)
      send_access(sacl_pkg::OP_INSTALL, {26'(i + 1), 6'd1}, i[0], 32'd7);
    send_access(sacl_pkg::OP_LOOKUP, {26'd3, 6'd1}, 1, 32'd9);
    send_access(sacl_pkg::OP_INSTALL, {26'h3FF_FFFF, 6'd1}, 0, 32'd10);
    send_access(sacl_pkg::OP_INSTALL, {26'h2AA_AAAA, 6'd1}, 1, 32'd11);
    drain();
    for (int p = 0; p < 6; p++) begin
      write_ways(ways_list[p]);
      for (int i = 0; i < 300; i++) begin
        if (p == 2 && i == 100) hold_off = 1;
        ts = ts + $urandom_range(0, 3);
        if ($urandom_range(0, 19) == 0) ts = $urandom();
        send_access($urandom_range(0, 2) == 0, pick_addr(), 1'($urandom_range(0, 1)), ts);
      end
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
